/* hdl/asfm_pkg.sv */
// Shared types, codes and constants of the adaptive symbol frequency model.
package asfm_pkg;

  localparam int unsigned MaxSymbolsDef = 256;
  localparam int unsigned CountW        = 32;
  localparam int unsigned SymW          = 8;
  localparam int unsigned AlphaW        = 9;
  localparam int unsigned StepW         = 16;
  localparam int unsigned LimitW        = 31;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 31;

  localparam logic [1:0] FuncEncode = 2'd0;
  localparam logic [1:0] FuncDecode = 2'd1;
  localparam logic [1:0] FuncUpdate = 2'd2;
  localparam logic [1:0] FuncClear  = 2'd3;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusBadSymbol = 2'd1;
  localparam logic [1:0] StatusBadTarget = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgAlphabetSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCountStep    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRescaleLimit = 2'd2;

  localparam logic [AlphaW-1:0] AlphaRst = 9'd256;
  localparam logic [StepW-1:0]  StepRst  = 16'd1;
  localparam logic [LimitW-1:0] LimitRst = 31'd65536;

  typedef struct packed {
    logic [1:0]        func;
    logic [SymW-1:0]   symbol;
    logic [CountW-1:0] target;
  } in_item_t;

  typedef struct packed {
    logic [SymW-1:0]   found_symbol;
    logic [CountW-1:0] cum_low;
    logic [CountW-1:0] cum_high;
    logic [CountW-1:0] total_count;
    logic [1:0]        status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ENC,
    S_DEC,
    S_UPD_RD,
    S_UPD_WR,
    S_UPD_TOT,
    S_UPD_CHK,
    S_RESC,
    S_CLR,
    S_DONE
  } state_e;

endpackage

/* hdl/asfm_ram.sv */
// Single-port-write, single-port-read count memory with registered read data.
module asfm_ram
  import asfm_pkg::*;
#(
  parameter int unsigned Depth = MaxSymbolsDef,
  parameter int unsigned AddrW = $clog2(MaxSymbolsDef),
  parameter int unsigned DataW = CountW
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/adaptive_symbol_frequency_model.sv */
// Top level of the adaptive symbol frequency model.
// Encode and decode walk the counts from entry zero, clear sets the active counts to one,
// an update may end in a rescale pass, and a bad symbol or target is answered without a walk;
// one item at a time, a new one accepted from the cycle in which the result is on the outputs.
// The count memory is walked one entry per cycle through one read and one write port.
// After reset a clearing pass sets every count to one; no item is accepted meanwhile,
// configuration writes are. Configuration resets to 256 / 1 / 65536.
module adaptive_symbol_frequency_model
  import asfm_pkg::*;
#(
  parameter int unsigned MaxSymbols = MaxSymbolsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o
);

  localparam int unsigned IdxW = $clog2(MaxSymbols);
  localparam int unsigned SzW  = $clog2(MaxSymbols + 1);
  localparam int unsigned AW   = (SzW > AlphaW) ? SzW : AlphaW;
  localparam int unsigned SW   = (SzW > SymW) ? SzW : SymW;
  localparam int unsigned RstSize = (MaxSymbols < 256) ? MaxSymbols : 256;
  localparam logic [IdxW-1:0]   LastEntry = IdxW'(MaxSymbols - 1);
  localparam logic [CountW-1:0] TotalRst  = CountW'(RstSize);

  state_e state_q, state_d;

  logic [AlphaW-1:0] alpha_q;
  logic [StepW-1:0]  step_q;
  logic [LimitW-1:0] limit_q;

  logic [SymW-1:0]   sym_q, sym_d;
  logic [CountW-1:0] target_q, target_d;

  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   pidx_q, pidx_d;
  logic              pend_q, pend_d;
  logic              iss_done_q, iss_done_d;
  logic [CountW-1:0] acc_q, acc_d;
  logic [CountW-1:0] total_q, total_d;

  logic [SymW-1:0]   fsym_q, fsym_d;
  logic [CountW-1:0] lo_q, lo_d;
  logic [CountW-1:0] hi_q, hi_d;
  logic [1:0]        status_q, status_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [CountW-1:0] ram_wdata, ram_rdata;

  logic [CountW-1:0] add_a, add_b, sum;
  logic [CountW-1:0] half;
  logic [SzW-1:0]    act_sz;
  logic [IdxW-1:0]   last_idx, sym_idx, end_idx;
  logic              in_sym_bad;
  logic              accept;

  asfm_ram #(
    .Depth(MaxSymbols),
    .AddrW(IdxW),
    .DataW(CountW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // saturate the alphabet size to 1..MaxSymbols
  always_comb begin
    if (alpha_q == '0) begin
      act_sz = SzW'(1);
    end else if (AW'(alpha_q) > AW'(MaxSymbols)) begin
      act_sz = SzW'(MaxSymbols);
    end else begin
      act_sz = SzW'(alpha_q);
    end
  end

  assign last_idx   = IdxW'(act_sz - SzW'(1));
  assign sym_idx    = IdxW'(SW'(sym_q));
  assign end_idx    = (state_q == S_ENC) ? sym_idx : last_idx;
  assign in_sym_bad = SW'(in_item_i.symbol) >= SW'(act_sz);
  assign half       = (ram_rdata >> 1) + CountW'(1);
  assign sum        = add_a + add_b;
  assign accept     = in_valid_i && (state_q == S_IDLE);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d    = state_q;
    sym_d      = sym_q;
    target_d   = target_q;
    idx_d      = idx_q;
    pidx_d     = pidx_q;
    pend_d     = 1'b0;
    iss_done_d = iss_done_q;
    acc_d      = acc_q;
    total_d    = total_q;
    fsym_d     = fsym_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    status_d   = status_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = CountW'(1);
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    add_a     = acc_q;
    add_b     = ram_rdata;

    unique case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
        idx_d  = IdxW'(idx_q + IdxW'(1));
        if (idx_q == LastEntry) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          sym_d      = in_item_i.symbol;
          target_d   = in_item_i.target;
          idx_d      = '0;
          iss_done_d = 1'b0;
          acc_d      = '0;
          fsym_d     = '0;
          lo_d       = '0;
          hi_d       = '0;
          status_d   = StatusOk;
          unique case (in_item_i.func)
            FuncEncode, FuncUpdate: begin
              fsym_d = in_item_i.symbol;
              if (in_sym_bad) begin
                status_d = StatusBadSymbol;
                state_d  = S_DONE;
              end else if (in_item_i.func == FuncEncode) begin
                state_d = S_ENC;
              end else begin
                state_d = S_UPD_RD;
              end
            end
            FuncDecode: begin
              if (in_item_i.target >= total_q) begin
                status_d = StatusBadTarget;
                state_d  = S_DONE;
              end else begin
                state_d = S_DEC;
              end
            end
            default: state_d = S_CLR;
          endcase
        end
      end

      S_ENC, S_DEC: begin
        ram_re = !iss_done_q;
        if (!iss_done_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q;
          idx_d  = IdxW'(idx_q + IdxW'(1));
          if (idx_q == end_idx) begin
            iss_done_d = 1'b1;
          end
        end
        if (pend_q) begin
          acc_d = sum;
          if (state_q == S_ENC) begin
            if (pidx_q == sym_idx) begin
              lo_d    = acc_q;
              hi_d    = sum;
              state_d = S_DONE;
            end
          end else if (sum > target_q) begin
            fsym_d  = SymW'(pidx_q);
            lo_d    = acc_q;
            hi_d    = sum;
            state_d = S_DONE;
          end else if (pidx_q == last_idx) begin
            status_d = StatusBadTarget;
            state_d  = S_DONE;
          end
        end
      end

      S_UPD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sym_idx;
        state_d   = S_UPD_WR;
      end

      S_UPD_WR: begin
        add_a     = ram_rdata;
        add_b     = CountW'(step_q);
        ram_we    = 1'b1;
        ram_waddr = sym_idx;
        ram_wdata = sum;
        state_d   = S_UPD_TOT;
      end

      S_UPD_TOT: begin
        add_a   = total_q;
        add_b   = CountW'(step_q);
        total_d = sum;
        state_d = S_UPD_CHK;
      end

      S_UPD_CHK: begin
        if (total_q >= CountW'(limit_q)) begin
          idx_d      = '0;
          iss_done_d = 1'b0;
          acc_d      = '0;
          state_d    = S_RESC;
        end else begin
          state_d = S_DONE;
        end
      end

      S_RESC: begin
        ram_re = !iss_done_q;
        if (!iss_done_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q;
          idx_d  = IdxW'(idx_q + IdxW'(1));
          if (idx_q == end_idx) begin
            iss_done_d = 1'b1;
          end
        end
        add_b = half;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q;
          ram_wdata = half;
          acc_d     = sum;
          if (pidx_q == last_idx) begin
            total_d = sum;
            state_d = S_DONE;
          end
        end
      end

      S_CLR: begin
        ram_we = 1'b1;
        idx_d  = IdxW'(idx_q + IdxW'(1));
        if (idx_q == last_idx) begin
          total_d = CountW'(act_sz);
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.found_symbol = fsym_q;
          out_d.cum_low     = lo_q;
          out_d.cum_high    = hi_q;
          out_d.total_count = total_q;
          out_d.status      = status_q;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaRst;
      step_q  <= StepRst;
      limit_q <= LimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAlphabetSize: alpha_q <= cfg_wdata_i[AlphaW-1:0];
        CfgCountStep:    step_q  <= cfg_wdata_i[StepW-1:0];
        CfgRescaleLimit: limit_q <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      iss_done_q  <= 1'b0;
      total_q     <= TotalRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      iss_done_q  <= iss_done_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q    <= sym_d;
    target_q <= target_d;
    pidx_q   <= pidx_d;
    acc_q    <= acc_d;
    fsym_q   <= fsym_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

endmodule
